@@ rtl/core/shallow_water_cell_diagnostics_assert.svh @@
// ----------------------------------------------------------------------------
// shallow_water_cell_diagnostics_assert
// Assertion macros shared by the cell diagnostics block.
// ----------------------------------------------------------------------------
`ifndef SHALLOW_WATER_CELL_DIAGNOSTICS_ASSERT_SVH
`define SHALLOW_WATER_CELL_DIAGNOSTICS_ASSERT_SVH
`define SWD_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl");
`define SWD_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl");
`endif

@@ rtl/core/swd_pkg.sv @@
// ----------------------------------------------------------------------------
// swd_pkg
// Shared constants and types for the cell diagnostics block.
// ----------------------------------------------------------------------------
package swd_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_GRAVITY = 2'd2;
    localparam logic [1:0] REG_DRY     = 2'd3;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] num;
        logic [63:0] den;
    } ar_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } ar_rsp_t;
endpackage

@@ rtl/core/swd_arith.sv @@
// ----------------------------------------------------------------------------
// swd_arith
// Shared restoring divider and bit-pair square root, one step per cycle.
// ----------------------------------------------------------------------------
module swd_arith
    import swd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ar_req_t req,
    output ar_rsp_t rsp
);
    logic        busy_reg;
    logic        done_reg;
    logic        div_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] x_reg, res_reg, den_reg, bit_reg;
    logic [63:0] rem_reg;
    logic [64:0] trial;
    logic [63:0] rb;

    assign rsp = '{done: done_reg, res: res_reg};
    assign rb = res_reg + bit_reg;
    assign trial = {rem_reg, x_reg[63]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                div_reg  <= req.is_div;
                cnt_reg  <= req.is_div ? 7'd64 : 7'd32;
                x_reg    <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            else if (busy_reg)
            begin
                if (div_reg)
                begin
                    x_reg <= {x_reg[62:0], 1'b0};
                    if (!trial[64])
                    begin
                        rem_reg <= trial[63:0];
                        res_reg <= {res_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], x_reg[63]};
                        res_reg <= {res_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    if (x_reg >= rb)
                    begin
                        x_reg   <= x_reg - rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

@@ rtl/core/shallow_water_cell_diagnostics.sv @@
// ----------------------------------------------------------------------------
// shallow_water_cell_diagnostics
// Per-cell velocity, speed and Froude number over a raster grid, with
// peak and minimum tracking; one result word per completed grid.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | sink      | in_valid/stall   | depth, flux_x, flux_y
// out     | source    | out_valid/stall  | five 31-bit diagnostics
// cfg     | sink      | cfg_we           | cfg_index, cfg_data
// A wet cell runs two divides, two roots and a Froude divide in turn on one
// shared unit, between a read state and an end state; with zero wave speed
// the Froude divide is skipped, at zero depth only the two roots run, and a
// dry cell runs none. The y-flux line store is read into a register when a
// cell is taken. A grid's last cell waits while an unaccepted result word is
// held; earlier cells are still taken. No clearing pass after reset.
module shallow_water_cell_diagnostics
    import swd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [30:0] depth,
    input  logic [31:0] flux_x,
    input  logic [31:0] flux_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] peak_speed,
    output logic [30:0] froude_max,
    output logic [30:0] speed_at_froude_max,
    output logic [30:0] depth_at_froude_max,
    output logic [30:0] min_wet_depth,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = $clog2(MAX_WIDTH + 1) + 1;
    localparam int SH = $clog2(MAX_HEIGHT + 1) + 1;
    localparam logic [63:0] SAT_SQ = 64'h3FFF_FFFF_0000_0001;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_U    = 8'b0000_0100,
        S_V    = 8'b0000_1000,
        S_SP   = 8'b0001_0000,
        S_C    = 8'b0010_0000,
        S_FR   = 8'b0100_0000,
        S_END  = 8'b1000_0000
    } st_t;

    st_t st_reg;
    logic [10:0] gw_reg, gh_reg;
    logic [30:0] grav_reg, dry_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [31:0] left_reg;
    logic [31:0] line_mem [MAX_WIDTH];
    logic [31:0] bot_rd_reg;
    logic [30:0] d_reg;
    logic [31:0] fx_reg, fy_reg, lf_reg;
    logic        c0_reg, r0_reg, re_reg, te_reg, wet_reg;
    logic [30:0] u_reg, sp_reg;
    logic [30:0] spk_reg, frk_reg, sak_reg, dak_reg, wmin_reg;
    logic        any_reg;
    logic        ov_reg;
    logic [30:0] o_sp_reg, o_fr_reg, o_sa_reg, o_da_reg, o_mw_reg;
    ar_req_t req;
    ar_rsp_t rsp;

    logic [SW-1:0] w_c;
    logic [SH-1:0] h_c;
    logic [CW-1:0] col_use;
    logic right_c, top_c;
    logic [32:0] sx, sy, ax, ay;
    logic [63:0] zsq;
    logic [30:0] r31;
    logic take;
    logic load_c;

    swd_arith u_arith (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_comb
    begin
        w_c = (gw_reg == 11'd0) ? SW'(1) :
              (32'(gw_reg) > 32'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(gw_reg);
        h_c = (gh_reg == 11'd0) ? SH'(1) :
              (32'(gh_reg) > 32'(MAX_HEIGHT)) ? SH'(MAX_HEIGHT) : SH'(gh_reg);
        col_use = col_reg;
        right_c = SW'(col_use) >= w_c - SW'(1);
        top_c = SH'(row_reg) >= h_c - SH'(1);
        sx = (c0_reg ? 33'd0 : {lf_reg[31], lf_reg})
           + (re_reg ? 33'd0 : {fx_reg[31], fx_reg});
        sy = (r0_reg ? 33'd0 : {bot_rd_reg[31], bot_rd_reg})
           + (te_reg ? 33'd0 : {fy_reg[31], fy_reg});
        ax = sx[32] ? -sx : sx;
        ay = sy[32] ? -sy : sy;
        zsq = ((ax != '0) ? SAT_SQ : 64'd0) + ((ay != '0) ? SAT_SQ : 64'd0);
        r31 = (rsp.res > 64'(SAT31)) ? SAT31 : rsp.res[30:0];
    end

    assign in_stall = (st_reg != S_IDLE);
    assign take = in_valid && !in_stall;
    assign load_c = (st_reg == S_END) && re_reg && te_reg && (!ov_reg || !out_stall);

    always_comb
    begin
        req = '0;
        case (st_reg)
            S_RD:
            begin
                req.start = wet_reg;
                if (d_reg == 31'd0)
                begin
                    // zero depth: quotients saturate unless the sum is zero
                    req.is_div = 1'b0;
                    req.num = zsq;
                end
                else
                begin
                    req.is_div = 1'b1;
                    req.num = {15'd0, ax, 16'd0};
                    req.den = {32'd0, d_reg, 1'b0};
                end
            end
            S_U:
            begin
                req.start = rsp.done;
                req.is_div = 1'b1;
                req.num = {15'd0, ay, 16'd0};
                req.den = {32'd0, d_reg, 1'b0};
            end
            S_V:
            begin
                req.start = rsp.done;
                req.is_div = 1'b0;
                req.num = 64'(u_reg) * 64'(u_reg) + 64'(r31) * 64'(r31);
            end
            S_SP:
            begin
                req.start = rsp.done;
                req.is_div = 1'b0;
                req.num = 64'(grav_reg) * 64'(d_reg);
            end
            S_C:
            begin
                req.start = rsp.done && (rsp.res != 64'd0);
                req.is_div = 1'b1;
                req.num = {17'd0, sp_reg, 16'd0};
                req.den = 64'(r31);
            end
            default: req = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
            line_mem[col_use] <= flux_y;
        if (take)
            bot_rd_reg <= line_mem[col_use];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            gw_reg <= 11'd1024; gh_reg <= 11'd1024;
            grav_reg <= 31'd642908; dry_reg <= 31'd7;
            col_reg <= '0; row_reg <= '0; left_reg <= '0;
            spk_reg <= '0; frk_reg <= '0; sak_reg <= '0; dak_reg <= '0;
            wmin_reg <= SAT31; any_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:   gw_reg <= cfg_data[10:0];
                    REG_HEIGHT:  gh_reg <= cfg_data[10:0];
                    REG_GRAVITY: grav_reg <= cfg_data;
                    REG_DRY:     dry_reg <= cfg_data;
                    default: ;
                endcase
            end
            ov_reg <= load_c || (ov_reg && out_stall);
            case (st_reg)
                S_IDLE:
                    if (take)
                    begin
                        d_reg <= depth; fx_reg <= flux_x; fy_reg <= flux_y;
                        lf_reg <= left_reg; left_reg <= flux_x;
                        c0_reg <= (col_use == '0); r0_reg <= (row_reg == '0);
                        re_reg <= right_c; te_reg <= top_c;
                        wet_reg <= depth >= dry_reg;
                        if (right_c)
                        begin
                            col_reg <= '0;
                            row_reg <= top_c ? '0 : row_reg + RW'(1);
                        end
                        else
                            col_reg <= col_reg + CW'(1);
                        st_reg <= S_RD;
                    end
                S_RD:
                    if (!wet_reg)
                        st_reg <= S_END;
                    else if (d_reg == 31'd0)
                        st_reg <= S_SP;
                    else
                        st_reg <= S_U;
                S_U:
                    if (rsp.done)
                    begin
                        u_reg <= r31;
                        st_reg <= S_V;
                    end
                S_V:
                    if (rsp.done)
                        st_reg <= S_SP;
                S_SP:
                    if (rsp.done)
                    begin
                        sp_reg <= r31;
                        any_reg <= 1'b1;
                        if (d_reg < wmin_reg) wmin_reg <= d_reg;
                        if (r31 > spk_reg) spk_reg <= r31;
                        st_reg <= S_C;
                    end
                S_C:
                    if (rsp.done)
                        st_reg <= (rsp.res != 64'd0) ? S_FR : S_END;
                S_FR:
                    if (rsp.done)
                    begin
                        if (r31 > frk_reg)
                        begin
                            frk_reg <= r31; sak_reg <= sp_reg;
                            dak_reg <= d_reg;
                        end
                        st_reg <= S_END;
                    end
                S_END:
                begin
                    if (!(re_reg && te_reg))
                        st_reg <= S_IDLE;
                    else if (load_c)
                    begin
                        o_sp_reg <= spk_reg; o_fr_reg <= frk_reg;
                        o_sa_reg <= sak_reg; o_da_reg <= dak_reg;
                        o_mw_reg <= any_reg ? wmin_reg : 31'd0;
                        spk_reg <= '0; frk_reg <= '0; sak_reg <= '0;
                        dak_reg <= '0; wmin_reg <= SAT31; any_reg <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign peak_speed = o_sp_reg;
    assign froude_max = o_fr_reg;
    assign speed_at_froude_max = o_sa_reg;
    assign depth_at_froude_max = o_da_reg;
    assign min_wet_depth = o_mw_reg;

`include "shallow_water_cell_diagnostics_assert.svh"
    `SWD_ASSERT_IMP(a_take_idle, take, st_reg == S_IDLE)
    `SWD_ASSERT_NXT(a_out_hold, ov_reg && out_stall, ov_reg)
    `SWD_ASSERT_NXT(a_out_stable, ov_reg && out_stall, $stable(o_sp_reg) && $stable(o_mw_reg))
endmodule
